// File: hdl/dq_pkg.sv
// dq_pkg: shared types and codes for the double-ended queue
// command and status codes, payload widths and the controller/datapath structs
// no dependencies

package dq_pkg;

    // payload widths fixed by the item format
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 7;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;

    // command codes
    localparam cmd_t CMD_PUSH_FRONT = 3'd0;
    localparam cmd_t CMD_PUSH_REAR  = 3'd1;
    localparam cmd_t CMD_POP_FRONT  = 3'd2;
    localparam cmd_t CMD_POP_REAR   = 3'd3;
    localparam cmd_t CMD_TRAVERSE   = 3'd4;

    // result status codes
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic    push_front;
        logic    push_rear;
        logic    pop_front;
        logic    pop_rear;
        logic    trav_start;
        logic    trav_next;
        logic    out_load;
        status_t out_status;
        logic    out_use_mem;
        logic    out_last_trav;
    } dq_ctl_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic empty;
        logic full;
        logic trav_last;
        logic out_free;
    } dq_sts_t;

endpackage

// File: hdl/dq_ifs.sv
// dq_req_if / dq_rsp_if: valid/ready channels of the double-ended queue
// command channel and result channel, each with source and sink modports
// depends on dq_pkg

interface dq_req_if import dq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    cmd_t                     cmd;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink (input valid, input cmd, input value, output ready);
endinterface

interface dq_rsp_if import dq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    status_t                  status;
    logic signed [DATA_W-1:0] data;
    logic                     last;
    logic [OCC_W-1:0]         occupancy;

    modport source (output valid, output status, output data, output last,
                    output occupancy, input ready);
    modport sink (input valid, input status, input data, input last,
                  input occupancy, output ready);
endinterface

// File: hdl/dq_ctrl.sv
// dq_ctrl: command sequencer of the double-ended queue
// decodes each command and steps pops and traversals through the datapath
// depends on dq_pkg

module dq_ctrl import dq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    input  cmd_t    cmd,
    input  dq_sts_t sts,
    output dq_ctl_t ctl,
    output logic    req_ready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_TRAV = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        ctl        = '0;
        req_ready  = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = sts.out_free;
                if (req_valid && sts.out_free)
                begin
                    unique case (cmd) inside
                        CMD_PUSH_FRONT, CMD_PUSH_REAR:
                        begin
                            ctl.out_load = 1'b1;
                            if (sts.full)
                            begin
                                ctl.out_status = ST_FULL;
                            end
                            else
                            begin
                                ctl.out_status = ST_OK;
                                ctl.push_front = (cmd == CMD_PUSH_FRONT);
                                ctl.push_rear  = (cmd == CMD_PUSH_REAR);
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_REAR:
                        begin
                            if (sts.empty)
                            begin
                                ctl.out_load   = 1'b1;
                                ctl.out_status = ST_EMPTY;
                            end
                            else
                            begin
                                ctl.pop_front = (cmd == CMD_POP_FRONT);
                                ctl.pop_rear  = (cmd == CMD_POP_REAR);
                                state_next    = S_POP;
                            end
                        end
                        CMD_TRAVERSE:
                        begin
                            if (sts.empty)
                            begin
                                ctl.out_load   = 1'b1;
                                ctl.out_status = ST_EMPTY;
                            end
                            else
                            begin
                                ctl.trav_start = 1'b1;
                                state_next     = S_TRAV;
                            end
                        end
                        default:
                        begin
                            // undefined command: plain ok result
                            ctl.out_load   = 1'b1;
                            ctl.out_status = ST_OK;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                // popped value is in the read register now
                if (sts.out_free)
                begin
                    ctl.out_load    = 1'b1;
                    ctl.out_status  = ST_OK;
                    ctl.out_use_mem = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_TRAV:
            begin
                // emit one element, fetch the next unless this was the rear
                if (sts.out_free)
                begin
                    ctl.out_load      = 1'b1;
                    ctl.out_status    = ST_OK;
                    ctl.out_use_mem   = 1'b1;
                    ctl.out_last_trav = 1'b1;
                    if (sts.trav_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ctl.trav_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/dq_dpath.sv
// dq_dpath: storage and pointers of the double-ended queue
// circular store, head and count registers, traversal walker, result register
// depends on dq_pkg

module dq_dpath import dq_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dq_ctl_t                  ctl,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     rsp_ready,
    output dq_sts_t                  sts,
    output logic                     rsp_valid,
    output status_t                  rsp_status,
    output logic signed [DATA_W-1:0] rsp_data,
    output logic                     rsp_last,
    output logic [OCC_W-1:0]         rsp_occupancy
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;

    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] trav_ptr_reg;
    logic [IDX_W-1:0] trav_ptr_next;
    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W-1:0] rem_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;

    logic                     out_valid_reg;
    status_t                  out_status_reg;
    logic signed [DATA_W-1:0] out_data_reg;
    logic                     out_last_reg;
    logic [OCC_W-1:0]         out_occ_reg;

    // circular index arithmetic
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? LAST_IDX : idx - 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] cnt);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(idx) + SUM_W'(cnt);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    // pointer updates and store addressing
    always_comb
    begin
        head_next     = head_reg;
        count_next    = count_reg;
        trav_ptr_next = trav_ptr_reg;
        rem_next      = rem_reg;
        wr_en         = 1'b0;
        wr_addr       = head_reg;
        rd_en         = 1'b0;
        rd_addr       = head_reg;
        if (ctl.push_front)
        begin
            head_next  = idx_dec(head_reg);
            wr_en      = 1'b1;
            wr_addr    = head_next;
            count_next = count_reg + 1'b1;
        end
        if (ctl.push_rear)
        begin
            wr_en      = 1'b1;
            wr_addr    = idx_add(head_reg, count_reg);
            count_next = count_reg + 1'b1;
        end
        if (ctl.pop_front)
        begin
            rd_en      = 1'b1;
            rd_addr    = head_reg;
            head_next  = idx_inc(head_reg);
            count_next = count_reg - 1'b1;
        end
        if (ctl.pop_rear)
        begin
            rd_en      = 1'b1;
            rd_addr    = idx_add(head_reg, count_reg - 1'b1);
            count_next = count_reg - 1'b1;
        end
        if (ctl.trav_start)
        begin
            rd_en         = 1'b1;
            rd_addr       = head_reg;
            trav_ptr_next = idx_inc(head_reg);
            rem_next      = count_reg;
        end
        if (ctl.trav_next)
        begin
            rd_en         = 1'b1;
            rd_addr       = trav_ptr_reg;
            trav_ptr_next = idx_inc(trav_ptr_reg);
            rem_next      = rem_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            count_reg    <= '0;
            trav_ptr_reg <= '0;
            rem_reg      <= '0;
        end
        else
        begin
            head_reg     <= head_next;
            count_reg    <= count_next;
            trav_ptr_reg <= trav_ptr_next;
            rem_reg      <= rem_next;
        end
    end

    // store with registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_status_reg <= ctl.out_status;
            out_data_reg   <= ctl.out_use_mem ? rd_data_reg : '0;
            out_last_reg   <= ctl.out_last_trav ? (rem_reg == ONE_CNT) : 1'b1;
            out_occ_reg    <= OCC_W'(count_next);
        end
    end

    // status toward the controller
    assign sts.empty     = (count_reg == '0);
    assign sts.full      = (count_reg == FULL_CNT);
    assign sts.trav_last = (rem_reg == ONE_CNT);
    assign sts.out_free  = !out_valid_reg || rsp_ready;

    assign rsp_valid     = out_valid_reg;
    assign rsp_status    = out_status_reg;
    assign rsp_data      = out_data_reg;
    assign rsp_last      = out_last_reg;
    assign rsp_occupancy = out_occ_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("held count exceeds store depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= LAST_IDX)
        else $error("head index outside store");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.push_front || ctl.push_rear) |-> !sts.full)
        else $error("push issued into a full store");

    a_trav_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.trav_next |-> (rem_reg > ONE_CNT))
        else $error("traversal stepped past the rear");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> (!out_valid_reg || rsp_ready))
        else $error("result register overwritten before transaction");

endmodule

// File: hdl/double_ended_queue.sv
// double_ended_queue: top level of the double-ended queue of signed 32-bit values
// joins the command sequencer (dq_ctrl) and the storage datapath (dq_dpath)
// depends on dq_pkg, dq_req_if, dq_rsp_if

// A deque of up to DEPTH signed 32-bit values in a circular two-port store.
// Commands arrive on req and results leave on rsp through one output register,
// so a command is taken only while that register is empty or its result leaves
// on rsp at the same edge. Pushes,
// refused pushes, pops or traversals of an empty queue and undefined commands
// give one result each from S_IDLE. A pop steps through S_POP, because the
// store read is registered: the value goes to the read register, then to the
// output register. A traverse of N held values starts the read at the front,
// then gives one value per cycle while rsp keeps up, the last one marked
// with last. The next command is taken once the final result of the current
// one sits in the output register and rsp accepts it. Entries come up
// undefined after reset; only entries that hold a pushed value are ever read.

module double_ended_queue import dq_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic            clk,
    input  logic            rst_n,
    dq_req_if.sink          req,
    dq_rsp_if.source        rsp
);

    dq_ctl_t ctl;
    dq_sts_t sts;

    // command sequencer
    dq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .cmd       (req.cmd),
        .sts       (sts),
        .ctl       (ctl),
        .req_ready (req.ready)
    );

    // storage, pointers and result register
    dq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .value         (req.value),
        .rsp_ready     (rsp.ready),
        .sts           (sts),
        .rsp_valid     (rsp.valid),
        .rsp_status    (rsp.status),
        .rsp_data      (rsp.data),
        .rsp_last      (rsp.last),
        .rsp_occupancy (rsp.occupancy)
    );

endmodule
